@@ rtl/core/tlbpt_pkg.sv @@
// Package for the TLB and page-table address translator.
// Holds the sizing constants, the page-table entry type and the TLB command
// and lookup structs. It depends on nothing.
package tlbpt_pkg;

    localparam int NUM_FRAMES  = 128;
    localparam int NUM_PAGES   = 256;
    localparam int TLB_ENTRIES = 16;

    localparam int ADDR_W      = 16;
    localparam int PAGE_W      = 8;
    localparam int OFFSET_W    = 8;
    localparam int PHYS_W      = 15;
    localparam int FRAME_NUM_W = 7;

    localparam int PAGE_IDX_W  = $clog2(NUM_PAGES);
    localparam int FRAME_W     = $clog2(NUM_FRAMES);
    localparam int COUNT_W     = $clog2(NUM_FRAMES + 1);
    localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);

    typedef struct packed {
        logic               present;
        logic               used;
        logic [FRAME_W-1:0] frame;
    } page_entry_t;

    typedef struct packed {
        logic                  fill_en;
        logic [PAGE_W-1:0]     fill_page;
        logic [FRAME_W-1:0]    fill_frame;
        logic                  drop_en;
        logic [PAGE_W-1:0]     drop_page;
    } tlb_cmd_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlb_res_t;

endpackage

@@ rtl/core/tlbpt_page_ram.sv @@
// Page-table memory: one write port and one read port with registered read data.
// Depends on tlbpt_pkg for the entry type and the depth.
module tlbpt_page_ram (
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [tlbpt_pkg::PAGE_IDX_W-1:0] rd_addr,
    output tlbpt_pkg::page_entry_t           rd_data,
    input  logic                             wr_en,
    input  logic [tlbpt_pkg::PAGE_IDX_W-1:0] wr_addr,
    input  tlbpt_pkg::page_entry_t           wr_data
);

    tlbpt_pkg::page_entry_t mem [tlbpt_pkg::NUM_PAGES];
    tlbpt_pkg::page_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/tlbpt_tlb.sv @@
// Fully associative TLB with parallel lookup, invalidation by page and
// round-robin refill. Depends on tlbpt_pkg for sizes and the command structs.
module tlbpt_tlb (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tlbpt_pkg::PAGE_W-1:0] lookup_page,
    output tlbpt_pkg::tlb_res_t          lookup_res,
    input  tlbpt_pkg::tlb_cmd_t          cmd
);

    logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_reg;
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_next;
    logic [tlbpt_pkg::PAGE_W-1:0]      page_reg  [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::FRAME_W-1:0]     frame_reg [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::TLB_IDX_W-1:0]   ptr_reg;
    logic [tlbpt_pkg::TLB_IDX_W-1:0]   ptr_next;
    logic                              drop_hit;
    logic [tlbpt_pkg::TLB_IDX_W-1:0]   drop_slot;

    // Lowest valid matching entry wins, so scan from the top down.
    always_comb
    begin
        lookup_res = '0;
        drop_hit   = 1'b0;
        drop_slot  = '0;
        for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && page_reg[i] == lookup_page)
            begin
                lookup_res.hit   = 1'b1;
                lookup_res.frame = frame_reg[i];
            end
            if (valid_reg[i] && page_reg[i] == cmd.drop_page)
            begin
                drop_hit  = 1'b1;
                drop_slot = tlbpt_pkg::TLB_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (cmd.drop_en && drop_hit)
        begin
            valid_next[drop_slot] = 1'b0;
        end
        if (cmd.fill_en)
        begin
            valid_next[ptr_reg] = 1'b1;
            if (ptr_reg == tlbpt_pkg::TLB_IDX_W'(tlbpt_pkg::TLB_ENTRIES - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_en)
        begin
            page_reg[ptr_reg]  <= cmd.fill_page;
            frame_reg[ptr_reg] <= cmd.fill_frame;
        end
    end

endmodule

@@ rtl/core/tlb_page_table_translator.sv @@
// Top level of the address translator; uses tlbpt_pkg, tlbpt_page_ram and tlbpt_tlb.
// A TLB or page-table hit completes from LOOKUP, and a fault with free frames left through
// FILL; a fault with memory full adds a victim scan of the page table, a used-bit clearing
// pass over every row when needed, and an eviction step before FILL when a victim is found.
// One transaction is in flight at a time and the next one can be accepted at the edge that
// takes the result; done cannot stall. After reset, busy stays high while the page table
// is cleared.
module tlb_page_table_translator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic                               cfg_write_data,
    input  logic                               start,
    output logic                               busy,
    input  logic [tlbpt_pkg::ADDR_W-1:0]       logical_address,
    output logic                               done,
    output logic [tlbpt_pkg::PHYS_W-1:0]       physical_address,
    output logic [tlbpt_pkg::FRAME_NUM_W-1:0]  frame_number,
    output logic                               tlb_hit,
    output logic                               page_fault
);

    // The sequencer. INIT clears the page table after reset, LOOKUP sees the
    // page-table read and the TLB result, SCAN walks the page table for a
    // victim, CLEAR wipes every used bit, EVICT drops the victim and FILL
    // installs the faulting page.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_CLEAR,
        ST_EVICT,
        ST_FILL
    } state_t;

    localparam logic [tlbpt_pkg::PAGE_IDX_W-1:0] LAST_PAGE =
        tlbpt_pkg::PAGE_IDX_W'(tlbpt_pkg::NUM_PAGES - 1);
    localparam logic [tlbpt_pkg::COUNT_W-1:0] FRAME_LIMIT =
        tlbpt_pkg::COUNT_W'(tlbpt_pkg::NUM_FRAMES);

    // The counter never exceeds NUM_FRAMES, so the modulo is a single compare.
    function automatic logic [tlbpt_pkg::FRAME_W-1:0] count_to_frame(
        input logic [tlbpt_pkg::COUNT_W-1:0] count
    );
        logic [tlbpt_pkg::FRAME_W-1:0] result;
        if (count == FRAME_LIMIT)
        begin
            result = '0;
        end
        else
        begin
            result = count[tlbpt_pkg::FRAME_W-1:0];
        end
        return result;
    endfunction

    // The frame is zero-extended to eight bits and then cut to the port width.
    function automatic logic [tlbpt_pkg::FRAME_NUM_W-1:0] frame_to_port(
        input logic [tlbpt_pkg::FRAME_W-1:0] frame
    );
        logic [7:0] wide;
        wide = 8'(frame);
        return wide[tlbpt_pkg::FRAME_NUM_W-1:0];
    endfunction

    state_t                                state_reg, state_next;
    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;
    logic [tlbpt_pkg::PHYS_W-1:0]          phys_reg, phys_next;
    logic [tlbpt_pkg::FRAME_NUM_W-1:0]     fnum_reg, fnum_next;
    logic                                  hit_reg, hit_next;
    logic                                  fault_reg, fault_next;
    logic                                  mode_reg, mode_next;
    logic [tlbpt_pkg::PAGE_W-1:0]          page_reg, page_next;
    logic [tlbpt_pkg::OFFSET_W-1:0]        offset_reg, offset_next;
    logic [tlbpt_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic                                  full_reg, full_next;
    logic [tlbpt_pkg::FRAME_W-1:0]         frame_reg, frame_next;
    logic [tlbpt_pkg::PAGE_IDX_W-1:0]      idx_reg, idx_next;
    logic                                  victim_found_reg, victim_found_next;
    logic [tlbpt_pkg::PAGE_IDX_W-1:0]      victim_page_reg, victim_page_next;
    logic                                  first_found_reg, first_found_next;
    logic [tlbpt_pkg::PAGE_IDX_W-1:0]      first_page_reg, first_page_next;
    logic [tlbpt_pkg::FRAME_W-1:0]         first_frame_reg, first_frame_next;

    logic                                  rd_en;
    logic [tlbpt_pkg::PAGE_IDX_W-1:0]      rd_addr;
    tlbpt_pkg::page_entry_t                rd_data;
    logic                                  wr_en;
    logic [tlbpt_pkg::PAGE_IDX_W-1:0]      wr_addr;
    tlbpt_pkg::page_entry_t                wr_data;

    tlbpt_pkg::tlb_cmd_t                   tlb_cmd;
    tlbpt_pkg::tlb_res_t                   tlb_res;

    logic [tlbpt_pkg::COUNT_W-1:0]         count_v;
    logic                                  full_v;
    logic                                  match_v;
    logic                                  ff_v;
    logic [tlbpt_pkg::PAGE_IDX_W-1:0]      fp_v;
    logic [tlbpt_pkg::FRAME_W-1:0]         fframe_v;

    tlbpt_page_ram u_page_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // The TLB is looked up with the latched page; its contents cannot change
    // between acceptance and the LOOKUP cycle.
    tlbpt_tlb u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_page (page_reg),
        .lookup_res  (tlb_res),
        .cmd         (tlb_cmd)
    );

    always_comb
    begin
        state_next        = state_reg;
        busy_next         = busy_reg;
        done_next         = 1'b0;
        phys_next         = phys_reg;
        fnum_next         = fnum_reg;
        hit_next          = hit_reg;
        fault_next        = fault_reg;
        mode_next         = mode_reg;
        page_next         = page_reg;
        offset_next       = offset_reg;
        count_next        = count_reg;
        full_next         = full_reg;
        frame_next        = frame_reg;
        idx_next          = idx_reg;
        victim_found_next = victim_found_reg;
        victim_page_next  = victim_page_reg;
        first_found_next  = first_found_reg;
        first_page_next   = first_page_reg;
        first_frame_next  = first_frame_reg;

        rd_en   = 1'b0;
        rd_addr = idx_reg + 1'b1;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        tlb_cmd = '0;

        count_v  = count_reg;
        full_v   = full_reg;
        match_v  = 1'b0;
        ff_v     = first_found_reg;
        fp_v     = first_page_reg;
        fframe_v = first_frame_reg;

        if (cfg_write_en)
        begin
            mode_next = cfg_write_data;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                // Write an all-clear entry into every page-table row.
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = '0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_PAGE)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
                    page_next   = logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
                    offset_next = logical_address[tlbpt_pkg::OFFSET_W-1:0];
                    busy_next   = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                if (tlb_res.hit || rd_data.present)
                begin
                    // Either hit marks the page used and completes here.
                    wr_en        = 1'b1;
                    wr_addr      = page_reg;
                    wr_data      = rd_data;
                    wr_data.used = 1'b1;
                    done_next    = 1'b1;
                    fault_next   = 1'b0;
                    busy_next    = 1'b0;
                    state_next   = ST_IDLE;
                    if (tlb_res.hit)
                    begin
                        hit_next  = 1'b1;
                        fnum_next = frame_to_port(tlb_res.frame);
                        phys_next = {frame_to_port(tlb_res.frame), offset_reg};
                    end
                    else
                    begin
                        hit_next           = 1'b0;
                        fnum_next          = frame_to_port(rd_data.frame);
                        phys_next          = {frame_to_port(rd_data.frame), offset_reg};
                        tlb_cmd.fill_en    = 1'b1;
                        tlb_cmd.fill_page  = page_reg;
                        tlb_cmd.fill_frame = rd_data.frame;
                    end
                end
                else
                begin
                    // Page fault. Once every frame has been handed out the
                    // memory is full; FIFO mode then restarts its frame order.
                    if (count_reg >= FRAME_LIMIT)
                    begin
                        if (!mode_reg)
                        begin
                            count_v = '0;
                        end
                        full_v = 1'b1;
                    end
                    count_next = count_v;
                    full_next  = full_v;
                    frame_next = count_to_frame(count_v);
                    if (full_v)
                    begin
                        victim_found_next = 1'b0;
                        first_found_next  = 1'b0;
                        idx_next          = '0;
                        rd_en             = 1'b1;
                        rd_addr           = '0;
                        state_next        = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
            end

            ST_SCAN:
            begin
                // rd_data holds the entry of page idx_reg. FIFO mode looks for
                // the first present page on the target frame, used-bit mode for
                // the first present page whose used bit is clear.
                if (mode_reg)
                begin
                    match_v = rd_data.present && !rd_data.used;
                end
                else
                begin
                    match_v = rd_data.present && rd_data.frame == frame_reg;
                end

                if (rd_data.present && !first_found_reg)
                begin
                    ff_v     = 1'b1;
                    fp_v     = idx_reg;
                    fframe_v = rd_data.frame;
                end
                first_found_next = ff_v;
                first_page_next  = fp_v;
                first_frame_next = fframe_v;

                if (match_v)
                begin
                    victim_found_next = 1'b1;
                    victim_page_next  = idx_reg;
                    if (mode_reg)
                    begin
                        frame_next = rd_data.frame;
                    end
                    state_next = ST_EVICT;
                end
                else if (idx_reg == LAST_PAGE)
                begin
                    if (mode_reg)
                    begin
                        // Nothing unused: every used bit gets cleared, after
                        // which the lowest present page is the victim.
                        victim_found_next = ff_v;
                        victim_page_next  = fp_v;
                        if (ff_v)
                        begin
                            frame_next = fframe_v;
                        end
                        idx_next   = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end

            ST_CLEAR:
            begin
                // Read one row ahead while writing back the row just read.
                wr_en        = 1'b1;
                wr_addr      = idx_reg;
                wr_data      = rd_data;
                wr_data.used = 1'b0;
                if (idx_reg == LAST_PAGE)
                begin
                    if (victim_found_reg)
                    begin
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end

            ST_EVICT:
            begin
                wr_en             = 1'b1;
                wr_addr           = victim_page_reg;
                wr_data.present   = 1'b0;
                wr_data.used      = 1'b0;
                wr_data.frame     = frame_reg;
                tlb_cmd.drop_en   = 1'b1;
                tlb_cmd.drop_page = tlbpt_pkg::PAGE_W'(victim_page_reg);
                state_next        = ST_FILL;
            end

            ST_FILL:
            begin
                wr_en              = 1'b1;
                wr_addr            = page_reg;
                wr_data.present    = 1'b1;
                wr_data.used       = 1'b1;
                wr_data.frame      = frame_reg;
                tlb_cmd.fill_en    = 1'b1;
                tlb_cmd.fill_page  = page_reg;
                tlb_cmd.fill_frame = frame_reg;
                if (count_reg < FRAME_LIMIT)
                begin
                    count_next = count_reg + 1'b1;
                end
                done_next  = 1'b1;
                hit_next   = 1'b0;
                fault_next = 1'b1;
                fnum_next  = frame_to_port(frame_reg);
                phys_next  = {frame_to_port(frame_reg), offset_reg};
                busy_next  = 1'b0;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            busy_reg         <= 1'b1;
            done_reg         <= 1'b0;
            phys_reg         <= '0;
            fnum_reg         <= '0;
            hit_reg          <= 1'b0;
            fault_reg        <= 1'b0;
            mode_reg         <= 1'b0;
            page_reg         <= '0;
            offset_reg       <= '0;
            count_reg        <= '0;
            full_reg         <= 1'b0;
            frame_reg        <= '0;
            idx_reg          <= '0;
            victim_found_reg <= 1'b0;
            victim_page_reg  <= '0;
            first_found_reg  <= 1'b0;
            first_page_reg   <= '0;
            first_frame_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            busy_reg         <= busy_next;
            done_reg         <= done_next;
            phys_reg         <= phys_next;
            fnum_reg         <= fnum_next;
            hit_reg          <= hit_next;
            fault_reg        <= fault_next;
            mode_reg         <= mode_next;
            page_reg         <= page_next;
            offset_reg       <= offset_next;
            count_reg        <= count_next;
            full_reg         <= full_next;
            frame_reg        <= frame_next;
            idx_reg          <= idx_next;
            victim_found_reg <= victim_found_next;
            victim_page_reg  <= victim_page_next;
            first_found_reg  <= first_found_next;
            first_page_reg   <= first_page_next;
            first_frame_reg  <= first_frame_next;
        end
    end

    assign busy             = busy_reg;
    assign done             = done_reg;
    assign physical_address = phys_reg;
    assign frame_number     = fnum_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;

endmodule

@@ tb/tlb_page_table_translator_tb.sv @@
// Self-checking testbench for the TLB and page-table address translator.
// Depends on tlbpt_pkg for sizing constants and on the tlb_page_table_translator RTL.
// A scoreboard class predicts every translation and checks each done strobe in order.
module tlb_page_table_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is bounded far above the slowest legal run: every item taking a full
    // victim scan plus a used-bit clearing pass plus the longest sender gap.
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_ITEMS  = 290;
    localparam int NUM_PHASES   = 6;
    localparam int HOT_PAGES    = 12;
    localparam int WARM_SPAN    = 48;

    // Victim selection once every frame is in use.
    typedef enum bit {
        REPL_FIFO     = 1'b0,
        REPL_USED_BIT = 1'b1
    } repl_mode_t;

    typedef struct packed {
        logic [tlbpt_pkg::PHYS_W-1:0]      phys;
        logic [tlbpt_pkg::FRAME_NUM_W-1:0] frame;
        logic                              hit;
        logic                              fault;
    } xlate_result_t;

    // The scoreboard holds a private copy of the translator state. Each accepted
    // transaction is translated here first, and the expected result is queued.
    class xlate_scoreboard;
        repl_mode_t                     mode;
        bit                             pg_present [tlbpt_pkg::NUM_PAGES];
        bit                             pg_used    [tlbpt_pkg::NUM_PAGES];
        logic [tlbpt_pkg::FRAME_W-1:0]  pg_frame   [tlbpt_pkg::NUM_PAGES];
        bit                             tl_valid   [tlbpt_pkg::TLB_ENTRIES];
        logic [tlbpt_pkg::PAGE_W-1:0]   tl_page    [tlbpt_pkg::TLB_ENTRIES];
        logic [tlbpt_pkg::FRAME_W-1:0]  tl_frame   [tlbpt_pkg::TLB_ENTRIES];
        int unsigned                    fill_ptr;
        int unsigned                    handed_out;
        bit                             all_frames_taken;
        xlate_result_t                  expected_q [$];
        int                             errors;
        int                             n_hit;
        int                             n_walk;
        int                             n_fault;
        int                             n_evict;
        int                             n_sweep;

        function new();
            mode = REPL_FIFO;
            for (int i = 0; i < tlbpt_pkg::NUM_PAGES; i++)
            begin
                pg_present[i] = 1'b0;
                pg_used[i]    = 1'b0;
                pg_frame[i]   = '0;
            end
            for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
            begin
                tl_valid[i] = 1'b0;
                tl_page[i]  = '0;
                tl_frame[i] = '0;
            end
            fill_ptr         = 0;
            handed_out       = 0;
            all_frames_taken = 1'b0;
            errors           = 0;
            n_hit            = 0;
            n_walk           = 0;
            n_fault          = 0;
            n_evict          = 0;
            n_sweep          = 0;
        endfunction

        // Lowest valid TLB slot holding the page, or -1.
        function int tlb_slot(logic [tlbpt_pkg::PAGE_W-1:0] page);
            for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
            begin
                if (tl_valid[i] && tl_page[i] == page)
                    return i;
            end
            return -1;
        endfunction

        function void tlb_write(logic [tlbpt_pkg::PAGE_W-1:0] page,
                                logic [tlbpt_pkg::FRAME_W-1:0] fr);
            tl_valid[fill_ptr] = 1'b1;
            tl_page[fill_ptr]  = page;
            tl_frame[fill_ptr] = fr;
            fill_ptr = (fill_ptr + 1) % tlbpt_pkg::TLB_ENTRIES;
        endfunction

        function int first_unused();
            for (int i = 0; i < tlbpt_pkg::NUM_PAGES; i++)
            begin
                if (pg_present[i] && !pg_used[i])
                    return i;
            end
            return -1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_address(logic [tlbpt_pkg::ADDR_W-1:0] addr);
            logic [tlbpt_pkg::PAGE_W-1:0]   page;
            logic [tlbpt_pkg::OFFSET_W-1:0] off;
            logic [tlbpt_pkg::FRAME_W-1:0]  fr;
            xlate_result_t                  res;
            int                             slot;
            int                             victim;

            page  = addr[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
            off   = addr[tlbpt_pkg::OFFSET_W-1:0];
            res   = '0;
            slot  = tlb_slot(page);
            if (slot >= 0)
            begin
                res.hit = 1'b1;
                fr = tl_frame[slot];
                pg_used[page] = 1'b1;
                n_hit++;
            end
            else if (pg_present[page])
            begin
                fr = pg_frame[page];
                pg_used[page] = 1'b1;
                tlb_write(page, fr);
                n_walk++;
            end
            else
            begin
                res.fault = 1'b1;
                n_fault++;
                if (handed_out >= tlbpt_pkg::NUM_FRAMES)
                begin
                    if (mode == REPL_FIFO)
                        handed_out = 0;
                    all_frames_taken = 1'b1;
                end
                fr = tlbpt_pkg::FRAME_W'(handed_out % tlbpt_pkg::NUM_FRAMES);
                if (all_frames_taken)
                begin
                    victim = -1;
                    if (mode == REPL_FIFO)
                    begin
                        for (int i = 0; i < tlbpt_pkg::NUM_PAGES && victim < 0; i++)
                        begin
                            if (pg_present[i] && pg_frame[i] == fr)
                                victim = i;
                        end
                    end
                    else
                    begin
                        victim = first_unused();
                        if (victim < 0)
                        begin
                            // Every resident page was used: clear all used bits and retry.
                            for (int i = 0; i < tlbpt_pkg::NUM_PAGES; i++)
                                pg_used[i] = 1'b0;
                            n_sweep++;
                            victim = first_unused();
                        end
                        if (victim >= 0)
                            fr = pg_frame[victim];
                    end
                    if (victim >= 0)
                    begin
                        pg_present[victim] = 1'b0;
                        slot = tlb_slot(tlbpt_pkg::PAGE_W'(victim));
                        if (slot >= 0)
                            tl_valid[slot] = 1'b0;
                        n_evict++;
                    end
                end
                pg_frame[page]   = fr;
                pg_present[page] = 1'b1;
                pg_used[page]    = 1'b1;
                tlb_write(page, fr);
                if (handed_out < tlbpt_pkg::NUM_FRAMES)
                    handed_out++;
            end
            res.frame = tlbpt_pkg::FRAME_NUM_W'(fr);
            res.phys  = tlbpt_pkg::PHYS_W'({fr, off});
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [tlbpt_pkg::PHYS_W-1:0] phys,
                                   logic [tlbpt_pkg::FRAME_NUM_W-1:0] fr,
                                   logic hit, logic fault);
            xlate_result_t want;

            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: done strobe with no transaction outstanding", $time);
                return;
            end
            want = expected_q.pop_front();
            if (phys !== want.phys)
            begin
                errors++;
                $display("%0t: physical_address mismatch: expected %h, actual %h",
                         $time, want.phys, phys);
            end
            if (fr !== want.frame)
            begin
                errors++;
                $display("%0t: frame_number mismatch: expected %0d, actual %0d",
                         $time, want.frame, fr);
            end
            if (hit !== want.hit)
            begin
                errors++;
                $display("%0t: tlb_hit mismatch: expected %b, actual %b",
                         $time, want.hit, hit);
            end
            if (fault !== want.fault)
            begin
                errors++;
                $display("%0t: page_fault mismatch: expected %b, actual %b",
                         $time, want.fault, fault);
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write_en;
    logic                              cfg_write_data;
    logic                              start;
    logic                              busy;
    logic [tlbpt_pkg::ADDR_W-1:0]      logical_address;
    logic                              done;
    logic [tlbpt_pkg::PHYS_W-1:0]      physical_address;
    logic [tlbpt_pkg::FRAME_NUM_W-1:0] frame_number;
    logic                              tlb_hit;
    logic                              page_fault;

    xlate_scoreboard                   sb;
    int                                cycle_count;
    int                                n_sent;
    logic [tlbpt_pkg::PAGE_W-1:0]      hot_pages [HOT_PAGES];
    logic [tlbpt_pkg::PAGE_W-1:0]      warm_base;
    repl_mode_t                        phase_mode [NUM_PHASES] = '{REPL_FIFO, REPL_USED_BIT,
                                                                   REPL_FIFO, REPL_USED_BIT,
                                                                   REPL_USED_BIT, REPL_FIFO};

    tlb_page_table_translator u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .start            (start),
        .busy             (busy),
        .logical_address  (logical_address),
        .done             (done),
        .physical_address (physical_address),
        .frame_number     (frame_number),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Watchdog. A hung handshake or a lost done strobe ends up here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tlb_page_table_translator regression: fail");
                $finish;
            end
        end
    end

    // Results cannot be held off, so every done strobe is checked at the edge
    // that ends its cycle. Values read here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(physical_address, frame_number, tlb_hit, page_fault);
    end

    // Presents one address and holds it until the block takes the transaction.
    // Start is left high so that back-to-back transactions need no extra edge.
    task automatic send_address(input logic [tlbpt_pkg::ADDR_W-1:0] addr);
        @(negedge clk);
        start           <= 1'b1;
        logical_address <= addr;
        do
            @(posedge clk);
        while (busy);
        sb.note_address(addr);
        n_sent++;
    endtask

    task automatic idle_cycles(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    // Stops sending and waits until every outstanding translation has come back
    // and the block reports itself free again.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // The replacement mode is only changed while the block is idle.
    task automatic write_mode(input repl_mode_t m);
        drain();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sb.mode = m;
    endtask

    task automatic refresh_locality();
        for (int k = 0; k < HOT_PAGES; k++)
            hot_pages[k] = tlbpt_pkg::PAGE_W'($urandom);
        warm_base = tlbpt_pkg::PAGE_W'($urandom);
    endtask

    // Address mix: a small hot set keeps the TLB hitting, a wider warm window
    // produces page-table hits after TLB refills push entries out, and uniform
    // pages keep memory full so that victims are chosen constantly.
    function automatic logic [tlbpt_pkg::ADDR_W-1:0] pick_address();
        int                           r;
        logic [tlbpt_pkg::PAGE_W-1:0] pg;

        r = $urandom_range(0, 99);
        if (r < 45)
            pg = hot_pages[$urandom_range(0, HOT_PAGES - 1)];
        else if (r < 65)
            pg = warm_base + tlbpt_pkg::PAGE_W'($urandom_range(0, WARM_SPAN - 1));
        else
            pg = tlbpt_pkg::PAGE_W'($urandom);
        return {pg, tlbpt_pkg::OFFSET_W'($urandom)};
    endfunction

    initial
    begin
        logic [tlbpt_pkg::PAGE_W-1:0] pg;

        sb              = new();
        n_sent          = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_write_data  = 1'b0;
        logical_address = '0;

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block clears its page table after reset; drain waits on busy.
        write_mode(REPL_FIFO);

        // Directed part. Extreme addresses first: a fault on page 0 then a TLB hit
        // on the same page, and the same for the top page.
        send_address(16'h0000);
        send_address(16'h00FF);
        send_address(16'hFF00);
        send_address(16'hFFFF);
        // Sixteen more faults wrap the round-robin refill pointer, so pages 0 and
        // 255 lose their TLB slots while staying resident in the page table.
        for (int p = 1; p <= tlbpt_pkg::TLB_ENTRIES; p++)
        begin
            pg = tlbpt_pkg::PAGE_W'(p);
            send_address({pg, (p % 2) ? 8'hAA : 8'h55});
        end
        // Page-table hits on the pages pushed out of the TLB, then a plain TLB hit.
        send_address(16'h00A5);
        send_address(16'hFF5A);
        send_address(16'h0780);

        // Random part. The first phase fills memory in FIFO mode; later phases
        // switch the replacement mode so that each mode takes over a state left by
        // the other at least once. The last phase runs with no sender gaps at all.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_mode(phase_mode[ph]);
            refresh_locality();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Once in the middle of the third phase the sender waits for the block to
                // empty completely before it carries on.
                if (ph == 2 && i == PHASE_ITEMS / 2)
                    drain();
                send_address(pick_address());
                if (ph < NUM_PHASES - 1 && (i % 100) < 70 && $urandom_range(0, 5) == 0)
                    idle_cycles($urandom_range(1, 9));
                if ($urandom_range(0, 49) == 0)
                    refresh_locality();
            end
        end

        drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Covered %0d translations: %0d TLB hits, %0d page-table hits, %0d faults,",
                 n_sent, sb.n_hit, sb.n_walk, sb.n_fault);
        $display("%0d evictions and %0d used-bit clears across both replacement modes.",
                 sb.n_evict, sb.n_sweep);
        if (sb.errors == 0)
            $display("tlb_page_table_translator regression: pass");
        else
            $display("tlb_page_table_translator regression: fail");
        $finish;
    end

endmodule
